// ----- rtl/core/mlfq_pkg.sv -----
// Shared types and constants for the three-level feedback-queue scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mlfq_pkg;

    localparam int LEVELS   = 3;
    localparam int LVL_W    = 2;
    localparam int ID_W     = 8;
    localparam int TIME_W   = 16;
    localparam int QUANT_W  = 8;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = ID_W + TIME_W;

    typedef logic [LVL_W-1:0] t_level;

    // level indexes
    localparam t_level LVL_0 = 2'd0;
    localparam t_level LVL_1 = 2'd1;
    localparam t_level LVL_2 = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_QUANTUM0 = 2'd0;
    localparam logic [1:0] REG_QUANTUM1 = 2'd1;
    localparam logic [1:0] REG_QUANTUM2 = 2'd2;

    localparam logic [QUANT_W-1:0] QUANTUM0_RST = 8'd5;
    localparam logic [QUANT_W-1:0] QUANTUM1_RST = 8'd10;
    localparam logic [QUANT_W-1:0] QUANTUM2_RST = 8'd20;

    // input item kinds
    localparam logic CMD_ADMIT    = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADMITTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REQUEUED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd4;

    typedef struct packed {
        logic capture;   // take the input item, search and start the head read
        logic execute;   // finish the item and load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } t_dp_status;

endpackage

// ----- rtl/core/mlfq_ctrl.sv -----
// Sequencer for the scheduler: accept an item, then execute it once the
// output register can take the result. Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cmd.capture   = i_s_axis_tvalid && (r_state == S_IDLE);
    assign o_cmd.execute   = (r_state == S_EXEC) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.execute) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_capture_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC))
        else $error("captured item did not move to execute");

    a_exec_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> (r_state == S_IDLE) && o_s_axis_tready)
        else $error("executed item did not return to idle");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.execute))
        else $error("capture and execute in the same cycle");

endmodule

// ----- rtl/core/mlfq_dp.sv -----
// Datapath: job store, ring pointers and counts per level, cursor, quantum
// registers and the output register. Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_dp
    import mlfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic                i_cmd_kind,
    input  logic [ID_W-1:0]     i_job_id,
    input  logic [TIME_W-1:0]   i_burst_time,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [QUANT_W-1:0]  i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status_code,
    output logic [ID_W-1:0]     o_served_id,
    output t_level              o_served_level,
    output t_level              o_next_level,
    output logic [QUANT_W-1:0]  o_units_run,
    output logic [TIME_W-1:0]   o_time_left
);

    localparam int ROWS   = LEVELS * QUEUE_DEPTH;
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(ROWS);

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] ROW_OFS  = ADDR_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic t_level lvl_next(input t_level l);
        lvl_next = (l == LVL_2) ? LVL_0 : l + LVL_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input t_level l,
                                                  input logic [PTR_W-1:0] p);
        addr_of = ADDR_W'(l) * ROW_OFS + ADDR_W'(p);
    endfunction

    logic [ENTRY_W-1:0] r_store [ROWS];
    logic [ENTRY_W-1:0] r_rdata;

    logic [PTR_W-1:0]   r_head  [LEVELS];
    logic [PTR_W-1:0]   r_tail  [LEVELS];
    logic [CNT_W-1:0]   r_count [LEVELS];
    t_level             r_cursor;
    logic [QUANT_W-1:0] r_quantum [LEVELS];

    // captured item
    logic               r_kind;
    logic [ID_W-1:0]    r_id;
    logic [TIME_W-1:0]  r_burst;
    logic               r_found;
    t_level             r_lvl;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ID_W-1:0]     r_sid;
    t_level              r_slvl;
    t_level              r_nlvl;
    logic [QUANT_W-1:0]  r_units;
    logic [TIME_W-1:0]   r_left;

    // search from the cursor, wrapping
    t_level c1, c2, srch_lvl;
    logic   srch_found;

    always_comb begin
        c1 = lvl_next(r_cursor);
        c2 = lvl_next(c1);
        srch_found = 1'b1;
        if (r_count[r_cursor] != '0) begin
            srch_lvl = r_cursor;
        end else if (r_count[c1] != '0) begin
            srch_lvl = c1;
        end else if (r_count[c2] != '0) begin
            srch_lvl = c2;
        end else begin
            srch_lvl   = LVL_0;
            srch_found = 1'b0;
        end
    end

    wire do_pop = i_cmd.capture && (i_cmd_kind == CMD_DISPATCH) && srch_found;

    // execute-stage result
    logic [TIME_W-1:0]   rem;
    logic [QUANT_W-1:0]  quant;
    logic [QUANT_W-1:0]  units;
    logic [TIME_W-1:0]   left;
    logic [CNT_W-1:0]    lower_cnt;
    t_level              dst;
    logic                push;
    t_level              push_lvl;
    logic [ENTRY_W-1:0]  push_entry;
    logic [STATUS_W-1:0] res_status;
    logic [ID_W-1:0]     res_sid;
    t_level              res_slvl;
    t_level              res_nlvl;
    logic [QUANT_W-1:0]  res_units;
    logic [TIME_W-1:0]   res_left;

    always_comb begin
        rem       = r_rdata[TIME_W-1:0];
        quant     = r_quantum[r_lvl];
        units     = ({{(TIME_W-QUANT_W){1'b0}}, quant} < rem) ? quant : rem[QUANT_W-1:0];
        left      = rem - {{(TIME_W-QUANT_W){1'b0}}, units};
        lower_cnt = (r_lvl == LVL_0) ? r_count[1] : r_count[2];
        dst       = ((r_lvl != LVL_2) && (lower_cnt != CNT_FULL)) ? r_lvl + LVL_W'(1) : r_lvl;

        push       = 1'b0;
        push_lvl   = LVL_0;
        push_entry = {r_id, r_burst};
        res_status = ST_IDLE;
        res_sid    = '0;
        res_slvl   = LVL_0;
        res_nlvl   = LVL_0;
        res_units  = '0;
        res_left   = '0;

        if (r_kind == CMD_ADMIT) begin
            res_sid  = r_id;
            res_left = r_burst;
            if (r_count[0] == CNT_FULL) begin
                res_status = ST_REJECTED;
            end else begin
                res_status = ST_ADMITTED;
                push       = 1'b1;
            end
        end else if (r_found) begin
            res_sid   = r_rdata[ENTRY_W-1:TIME_W];
            res_slvl  = r_lvl;
            res_units = units;
            res_left  = left;
            if (left == '0) begin
                res_status = ST_COMPLETE;
            end else begin
                res_status = ST_REQUEUED;
                res_nlvl   = dst;
                push       = 1'b1;
                push_lvl   = dst;
                push_entry = {r_rdata[ENTRY_W-1:TIME_W], left};
            end
        end
    end

    wire do_push = i_cmd.execute && push;

    assign o_status.out_free = !r_out_valid || i_out_ready;

    // job store: one write (execute), one registered read (capture)
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[addr_of(push_lvl, r_tail[push_lvl])] <= push_entry;
        end
        if (do_pop) begin
            r_rdata <= r_store[addr_of(srch_lvl, r_head[srch_lvl])];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_cursor     <= LVL_0;
            r_quantum[0] <= QUANTUM0_RST;
            r_quantum[1] <= QUANTUM1_RST;
            r_quantum[2] <= QUANTUM2_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_QUANTUM0: r_quantum[0] <= i_cfg_data;
                    REG_QUANTUM1: r_quantum[1] <= i_cfg_data;
                    REG_QUANTUM2: r_quantum[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            // pop and push never fall in the same cycle
            if (do_pop) begin
                r_head[srch_lvl]  <= ptr_next(r_head[srch_lvl]);
                r_count[srch_lvl] <= r_count[srch_lvl] - CNT_W'(1);
            end
            if (do_push) begin
                r_tail[push_lvl]  <= ptr_next(r_tail[push_lvl]);
                r_count[push_lvl] <= r_count[push_lvl] + CNT_W'(1);
            end
            if (i_cmd.execute && (r_kind == CMD_DISPATCH) && r_found) begin
                r_cursor <= lvl_next(r_lvl);
            end
            if (i_cmd.execute) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_cmd_kind;
            r_id    <= i_job_id;
            r_burst <= i_burst_time;
            r_found <= srch_found;
            r_lvl   <= srch_lvl;
        end
        if (i_cmd.execute) begin
            r_status <= res_status;
            r_sid    <= res_sid;
            r_slvl   <= res_slvl;
            r_nlvl   <= res_nlvl;
            r_units  <= res_units;
            r_left   <= res_left;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status_code  = r_status;
    assign o_served_id    = r_sid;
    assign o_served_level = r_slvl;
    assign o_next_level   = r_nlvl;
    assign o_units_run    = r_units;
    assign o_time_left    = r_left;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count[0] <= CNT_FULL) && (r_count[1] <= CNT_FULL) && (r_count[2] <= CNT_FULL))
        else $error("level count above ring depth");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor != 2'd3)
        else $error("cursor left the level range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |-> (r_count[srch_lvl] != '0))
        else $error("pop from an empty level");

    a_exec_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.execute |=> r_out_valid)
        else $error("executed item left no result");

endmodule

// ----- rtl/core/mlfq_three_level_scheduler.sv -----
// Top level of the three-level feedback-queue scheduler: sequencer plus
// datapath. Depends on mlfq_pkg, mlfq_ctrl and mlfq_dp.
`timescale 1ns / 1ps

// Each admit or dispatch item is first accepted (level search, head read
// from the synchronous job store) and then executed (quantum grant, requeue
// write, result into the output register). Execution waits while the output
// register holds a result not yet taken; no new item is accepted until the
// current one has executed. No clearing pass after reset: the store is only
// read at queued entries.
module mlfq_three_level_scheduler
    import mlfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [23:0]  i_s_axis_tdata,   // job_id[7:0], burst_time[23:8]
    input  logic         i_s_axis_tuser,   // cmd[0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // served_id[7:0], served_level[9:8], next_level[11:10], units_run[19:12],
    // time_left[35:20], zero[39:36]
    output logic [39:0]  o_m_axis_tdata,
    output logic [2:0]   o_m_axis_tuser,   // status[2:0]
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    logic [ID_W-1:0]    served_id;
    t_level             served_level;
    t_level             next_level;
    logic [QUANT_W-1:0] units_run;
    logic [TIME_W-1:0]  time_left;

    mlfq_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (dp_status),
        .o_cmd           (dp_cmd)
    );

    mlfq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_cmd_kind     (i_s_axis_tuser),
        .i_job_id       (i_s_axis_tdata[7:0]),
        .i_burst_time   (i_s_axis_tdata[23:8]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_status_code  (o_m_axis_tuser),
        .o_served_id    (served_id),
        .o_served_level (served_level),
        .o_next_level   (next_level),
        .o_units_run    (units_run),
        .o_time_left    (time_left)
    );

    assign o_m_axis_tdata = {4'b0000, time_left, units_run, next_level, served_level, served_id};

endmodule
